[sv/block_buffer_cache_lru_top_assert.svh]
// Assertion macros for the buffer cache directory top level.
// Included by block_buffer_cache_lru_top.sv; expects clk and arst_n in scope.
`ifndef BLOCK_BUFFER_CACHE_LRU_TOP_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LRU_TOP_ASSERT_SVH

// same-cycle implication
`define BBC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define BBC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

[sv/bbc_pkg.sv]
// Shared types and constants for the buffer cache directory.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

	localparam int NUM_SLOTS = 32;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int IDX_W     = 5;
	localparam int DEV_W     = 8;
	localparam int BLK_W     = 32;
	localparam int TAG_W     = DEV_W + BLK_W;
	localparam int CNT_W     = 8;
	localparam int STAMP_W   = 32;
	localparam int ST_W      = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		FN_GET     = 2'd0,
		FN_RELEASE = 2'd1,
		FN_PIN     = 2'd2,
		FN_UNPIN   = 2'd3
	} func_t;

	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
	localparam logic [ST_W-1:0] ST_UNDER  = 2'd2;
	localparam logic [ST_W-1:0] ST_OVER   = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic scan_rd;
		logic commit_get;
		logic commit_op;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
	} dp_sts_t;

endpackage

`default_nettype wire

[sv/block_buffer_cache_lru_top.sv]
// Buffer cache directory: get scans all NUM_SLOTS slots through one tag/stamp
// read port, one slot a cycle, then passes a drain state and commits; release,
// pin and unpin commit straight after accept. done is registered from the commit.
// One item in flight; busy is high until its commit cycle ends.
// The receiver cannot stall: done marks each result beat for one cycle.
// Async reset clears all counts, presence, valid and stamp marks.
`timescale 1ns / 1ps
`default_nettype none

module block_buffer_cache_lru_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  func,
	input  wire logic [bbc_pkg::DEV_W-1:0]   device,
	input  wire logic [bbc_pkg::BLK_W-1:0]   block_number,
	input  wire logic [bbc_pkg::IDX_W-1:0]   slot_index,
	input  wire logic [bbc_pkg::STAMP_W-1:0] now_ticks,
	output logic                             done,
	output logic [bbc_pkg::IDX_W-1:0]        slot,
	output logic                             hit,
	output logic                             needs_read,
	output logic [bbc_pkg::CNT_W-1:0]        new_count,
	output logic [bbc_pkg::ST_W-1:0]         status
);
	import bbc_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	bbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bbc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.device       (device),
		.block_number (block_number),
		.slot_index   (slot_index),
		.now_ticks    (now_ticks),
		.done         (done),
		.slot         (slot),
		.hit          (hit),
		.needs_read   (needs_read),
		.new_count    (new_count),
		.status       (status)
	);

`include "block_buffer_cache_lru_top_assert.svh"

	`BBC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
	`BBC_ASSERT_NXT(a_commit_done, cmd.commit_get || cmd.commit_op, done, "commit gave no beat")
	`BBC_ASSERT_IMP(a_hit_valid, done && hit, !needs_read, "hit on slot with invalid contents")
	`BBC_ASSERT_IMP(a_nofree_zero, done && (status == ST_NOFREE), (slot == '0) && (new_count == '0) && !hit, "no-free beat not cleared")

endmodule

`default_nettype wire

[sv/bbc_ctrl.sv]
// Sequencing state machine for the buffer cache directory.
// Depends on bbc_pkg; drives the command struct of bbc_dpath.
`timescale 1ns / 1ps
`default_nettype none

module bbc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [1:0]       func,
	input  wire bbc_pkg::dp_sts_t sts,
	output bbc_pkg::dp_cmd_t      cmd,
	output logic                  busy
);
	import bbc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_GET   = 5'b01000,
		S_OPER  = 5'b10000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = (func == FN_GET) ? S_SCAN : S_OPER;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_nxt = S_DRAIN;
				end
			end
			// last read still in its compare stage
			S_DRAIN: begin
				state_nxt = S_GET;
			end
			S_GET: begin
				cmd.commit_get = 1'b1;
				state_nxt      = S_IDLE;
			end
			S_OPER: begin
				cmd.commit_op = 1'b1;
				state_nxt     = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

[sv/bbc_dpath.sv]
// Slot storage, scan compare and count update for the buffer cache directory.
// Depends on bbc_pkg; commanded by bbc_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module bbc_dpath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire bbc_pkg::dp_cmd_t          cmd,
	output bbc_pkg::dp_sts_t               sts,
	input  wire logic [1:0]                func,
	input  wire logic [bbc_pkg::DEV_W-1:0]   device,
	input  wire logic [bbc_pkg::BLK_W-1:0]   block_number,
	input  wire logic [bbc_pkg::IDX_W-1:0]   slot_index,
	input  wire logic [bbc_pkg::STAMP_W-1:0] now_ticks,
	output logic                           done,
	output logic [bbc_pkg::IDX_W-1:0]      slot,
	output logic                           hit,
	output logic                           needs_read,
	output logic [bbc_pkg::CNT_W-1:0]      new_count,
	output logic [bbc_pkg::ST_W-1:0]       status
);
	import bbc_pkg::*;

	// request held for the whole item
	logic [1:0]         req_func_q;
	logic [DEV_W-1:0]   req_dev_q;
	logic [BLK_W-1:0]   req_blk_q;
	logic [IDX_W-1:0]   req_idx_q;
	logic [STAMP_W-1:0] req_now_q;

	// per-slot state
	logic [TAG_W-1:0]   tag_mem   [NUM_SLOTS];
	logic [STAMP_W-1:0] stamp_mem [NUM_SLOTS];
	logic [CNT_W-1:0]   cnt_q     [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] present_q;
	logic [NUM_SLOTS-1:0] cv_q;
	logic [NUM_SLOTS-1:0] stamp_vld_q;

	// scan
	logic [SLOT_W-1:0]  ptr_q;
	logic               rd_vld_s1;
	logic [SLOT_W-1:0]  rd_idx_s1;
	logic [TAG_W-1:0]   tag_rd_s1;
	logic [STAMP_W-1:0] stamp_rd_s1;

	logic               hit_fnd_q;
	logic [SLOT_W-1:0]  hit_idx_q;
	logic               free_fnd_q;
	logic [SLOT_W-1:0]  best_q;
	logic [STAMP_W-1:0] best_stamp_q;

	logic               committing;
	logic [SLOT_W-1:0]  tgt;
	logic [SLOT_W-1:0]  rsel;
	logic [CNT_W-1:0]   cnt_rd;
	logic               match_s1;
	logic               free_s1;
	logic [STAMP_W-1:0] stamp_eff;
	logic               sat;
	logic [CNT_W-1:0]   cnt_inc;
	logic [CNT_W-1:0]   cnt_dec;
	logic               oor;

	logic               cnt_we;
	logic [CNT_W-1:0]   cnt_wd;
	logic               tag_we;
	logic               stamp_we;
	logic               cv_set;
	logic [IDX_W-1:0]   r_slot;
	logic               r_hit;
	logic               r_nr;
	logic [CNT_W-1:0]   r_cnt;
	logic [ST_W-1:0]    r_st;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_func_q <= func;
			req_dev_q  <= device;
			req_blk_q  <= block_number;
			req_idx_q  <= slot_index;
			req_now_q  <= now_ticks;
		end
	end

	assign sts.scan_last = (ptr_q == SLOT_W'(NUM_SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.scan_rd) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// tag and stamp stores: one write, one registered read
	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q;
		if (cmd.scan_rd) begin
			tag_rd_s1   <= tag_mem[ptr_q];
			stamp_rd_s1 <= stamp_mem[ptr_q];
		end
		if (tag_we) begin
			tag_mem[tgt] <= {req_dev_q, req_blk_q};
		end
		if (stamp_we) begin
			stamp_mem[tgt] <= req_now_q;
		end
	end

	assign committing = cmd.commit_get | cmd.commit_op;
	assign tgt  = cmd.commit_get ? (hit_fnd_q ? hit_idx_q : best_q) : SLOT_W'(req_idx_q);
	assign rsel = committing ? tgt : rd_idx_s1;
	assign cnt_rd = cnt_q[rsel];

	assign match_s1  = present_q[rd_idx_s1] && (tag_rd_s1 == {req_dev_q, req_blk_q});
	assign free_s1   = (cnt_rd == '0);
	// a stamp never written reads as zero
	assign stamp_eff = stamp_vld_q[rd_idx_s1] ? stamp_rd_s1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
		end else if (cmd.load) begin
			hit_fnd_q  <= 1'b0;
			free_fnd_q <= 1'b0;
		end else if (rd_vld_s1) begin
			if (match_s1) begin
				hit_fnd_q <= 1'b1;
			end
			if (free_s1) begin
				free_fnd_q <= 1'b1;
			end
		end
	end

	// lowest index wins on equal stamps: strict less-than
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (match_s1 && !hit_fnd_q) begin
				hit_idx_q <= rd_idx_s1;
			end
			if (free_s1 && (!free_fnd_q || (stamp_eff < best_stamp_q))) begin
				best_q       <= rd_idx_s1;
				best_stamp_q <= stamp_eff;
			end
		end
	end

	assign sat     = (cnt_rd == CNT_MAX);
	assign cnt_inc = sat ? cnt_rd : cnt_rd + 1'b1;
	assign cnt_dec = cnt_rd - 1'b1;
	assign oor     = (32'(req_idx_q) >= 32'(NUM_SLOTS));

	always_comb begin
		r_slot   = IDX_W'(tgt);
		r_hit    = 1'b0;
		r_nr     = 1'b0;
		r_cnt    = cnt_rd;
		r_st     = ST_OK;
		cnt_we   = 1'b0;
		cnt_wd   = cnt_rd;
		tag_we   = 1'b0;
		stamp_we = 1'b0;
		cv_set   = 1'b0;
		if (cmd.commit_get) begin
			if (hit_fnd_q) begin
				r_hit  = 1'b1;
				r_nr   = ~cv_q[tgt];
				cv_set = 1'b1;
				cnt_we = ~sat;
				cnt_wd = cnt_inc;
				r_cnt  = cnt_inc;
				r_st   = sat ? ST_OVER : ST_OK;
			end else if (free_fnd_q) begin
				tag_we = 1'b1;
				cv_set = 1'b1;
				cnt_we = 1'b1;
				cnt_wd = CNT_W'(1);
				r_nr   = 1'b1;
				r_cnt  = CNT_W'(1);
			end else begin
				r_slot = '0;
				r_cnt  = '0;
				r_st   = ST_NOFREE;
			end
		end else if (cmd.commit_op) begin
			if (oor) begin
				r_slot = req_idx_q;
				r_cnt  = '0;
			end else if (req_func_q == FN_PIN) begin
				cnt_we = ~sat;
				cnt_wd = cnt_inc;
				r_cnt  = cnt_inc;
				r_st   = sat ? ST_OVER : ST_OK;
			end else if (cnt_rd == '0) begin
				r_cnt = '0;
				r_st  = ST_UNDER;
			end else begin
				cnt_we   = 1'b1;
				cnt_wd   = cnt_dec;
				r_cnt    = cnt_dec;
				// only a release that frees the slot is stamped
				stamp_we = (req_func_q == FN_RELEASE) && (cnt_dec == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				cnt_q[i] <= '0;
			end
			present_q   <= '0;
			cv_q        <= '0;
			stamp_vld_q <= '0;
		end else begin
			if (cnt_we) begin
				cnt_q[tgt] <= cnt_wd;
			end
			if (tag_we) begin
				present_q[tgt] <= 1'b1;
			end
			if (cv_set) begin
				cv_q[tgt] <= 1'b1;
			end
			if (stamp_we) begin
				stamp_vld_q[tgt] <= 1'b1;
			end
		end
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= committing;
		end
	end

	always_ff @(posedge clk) begin
		if (committing) begin
			slot       <= r_slot;
			hit        <= r_hit;
			needs_read <= r_nr;
			new_count  <= r_cnt;
			status     <= r_st;
		end
	end

endmodule

`default_nettype wire
